/* rtl/s32a_pkg.sv */
// Shared types and constants for the stack VM 32-bit integer ALU.
// Used by every module of the block; depends on nothing.
`default_nettype none
package s32a_pkg;

  localparam int unsigned XLEN = 32;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB = 5'd1,  OP_MUL = 5'd2,  OP_SDIV = 5'd3,
    OP_UDIV = 5'd4,  OP_SREM = 5'd5, OP_UREM = 5'd6, OP_AND = 5'd7,
    OP_OR   = 5'd8,  OP_XOR = 5'd9,  OP_SHL = 5'd10, OP_SHR = 5'd11,
    OP_SAR  = 5'd12, OP_EQ  = 5'd13, OP_SLT = 5'd14, OP_SLE = 5'd15,
    OP_ULT  = 5'd16, OP_ULE = 5'd17
  } op_t;

  typedef enum logic [1:0] {
    TRAP_NONE = 2'd0,
    TRAP_DIV0 = 2'd1,
    TRAP_OVF  = 2'd2
  } trap_t;

  // Payload carried through the divider pipeline
  typedef struct packed {
    logic [XLEN-1:0] simple;   // result of the non-dividing operations
    trap_t           trap;
    logic            is_div;
    logic            want_rem;
    logic            neg;
    logic [XLEN-1:0] rem;      // partial remainder
    logic [XLEN-1:0] quo;      // dividend shifting out, quotient shifting in
    logic [XLEN-1:0] dvs;      // divisor magnitude
  } stage_t;

endpackage
`default_nettype wire

/* rtl/s32a_front.sv */
// Input register and decode stage: simple ops, multiply, divider setup.
// Depends on s32a_pkg.
`default_nettype none
module s32a_front
  import s32a_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [4:0]       in_op,
  input  wire logic [XLEN-1:0]  in_lhs,
  input  wire logic [XLEN-1:0]  in_rhs,
  output logic                  out_vld,
  output stage_t                out_pl
);

  logic            vld0;
  logic [4:0]      op0;
  logic [XLEN-1:0] l0, r0;
  stage_t          pl_next;
  logic [XLEN-1:0] lmag, rmag, shl_v, shr_v, sar_v;
  logic            big_sh, slt, ult;

  // Capture the transfer
  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else if (en) vld0 <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= in_op;
      l0  <= in_lhs;
      r0  <= in_rhs;
    end
  end

  // Decode and compute the short operations
  always_comb begin
    lmag   = l0[XLEN-1] ? (~l0 + 1'b1) : l0;
    rmag   = r0[XLEN-1] ? (~r0 + 1'b1) : r0;
    big_sh = |r0[XLEN-1:5];
    shl_v  = big_sh ? '0 : (l0 << r0[4:0]);
    shr_v  = big_sh ? '0 : (l0 >> r0[4:0]);
    sar_v  = big_sh ? {XLEN{l0[XLEN-1]}} : XLEN'($signed(l0) >>> r0[4:0]);
    slt    = $signed(l0) < $signed(r0);
    ult    = l0 < r0;
    pl_next = '0;
    pl_next.trap = TRAP_NONE;
    case (op0)
      OP_ADD:  pl_next.simple = l0 + r0;
      OP_SUB:  pl_next.simple = l0 - r0;
      OP_MUL:  pl_next.simple = l0 * r0;
      OP_AND:  pl_next.simple = l0 & r0;
      OP_OR:   pl_next.simple = l0 | r0;
      OP_XOR:  pl_next.simple = l0 ^ r0;
      OP_SHL:  pl_next.simple = shl_v;
      OP_SHR:  pl_next.simple = shr_v;
      OP_SAR:  pl_next.simple = sar_v;
      OP_EQ:   pl_next.simple = XLEN'(l0 == r0);
      OP_SLT:  pl_next.simple = XLEN'(slt);
      OP_SLE:  pl_next.simple = XLEN'(slt || (l0 == r0));
      OP_ULT:  pl_next.simple = XLEN'(ult);
      OP_ULE:  pl_next.simple = XLEN'(ult || (l0 == r0));
      OP_SDIV, OP_SREM: begin
        pl_next.is_div   = 1'b1;
        pl_next.want_rem = (op0 == OP_SREM);
        pl_next.neg      = (op0 == OP_SREM) ? l0[XLEN-1] : (l0[XLEN-1] ^ r0[XLEN-1]);
        pl_next.quo      = lmag;
        pl_next.dvs      = rmag;
        if (r0 == '0) pl_next.trap = TRAP_DIV0;
        else if (op0 == OP_SDIV && l0 == {1'b1, {(XLEN-1){1'b0}}} && r0 == '1)
          pl_next.trap = TRAP_OVF;
      end
      OP_UDIV, OP_UREM: begin
        pl_next.is_div   = 1'b1;
        pl_next.want_rem = (op0 == OP_UREM);
        pl_next.quo      = l0;
        pl_next.dvs      = r0;
        if (r0 == '0) pl_next.trap = TRAP_DIV0;
      end
      default: pl_next.simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld0;
  end
  always_ff @(posedge clk) begin
    if (en) out_pl <= pl_next;
  end

endmodule
`default_nettype wire

/* rtl/s32a_div_step.sv */
// One restoring-division step: produces one quotient bit per stage.
// Depends on s32a_pkg.
`default_nettype none
module s32a_div_step
  import s32a_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_vld,
  input  stage_t      in_pl,
  output logic        out_vld,
  output stage_t      out_pl
);

  logic [XLEN:0] trial, diff;
  stage_t        pl_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial   = {in_pl.rem, in_pl.quo[XLEN-1]};
    diff    = trial - {1'b0, in_pl.dvs};
    pl_next = in_pl;
    if (!diff[XLEN]) begin
      pl_next.rem = diff[XLEN-1:0];
      pl_next.quo = {in_pl.quo[XLEN-2:0], 1'b1};
    end else begin
      pl_next.rem = trial[XLEN-1:0];
      pl_next.quo = {in_pl.quo[XLEN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) out_pl <= pl_next;
  end

endmodule
`default_nettype wire

/* rtl/s32a_back.sv */
// Result select, sign fix and output register.
// Depends on s32a_pkg.
`default_nettype none
module s32a_back
  import s32a_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  stage_t                in_pl,
  output logic                  out_vld,
  output logic [XLEN-1:0]       out_value,
  output logic [1:0]            out_trap
);

  logic [XLEN-1:0] mag, value_next;

  // Pick quotient or remainder, restore the sign, zero on a trap
  always_comb begin
    mag = in_pl.want_rem ? in_pl.rem : in_pl.quo;
    if (in_pl.trap != TRAP_NONE) value_next = '0;
    else if (!in_pl.is_div)      value_next = in_pl.simple;
    else if (in_pl.neg)          value_next = ~mag + 1'b1;
    else                         value_next = mag;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= value_next;
      out_trap  <= in_pl.trap;
    end
  end

endmodule
`default_nettype wire

/* rtl/stack_vm_int32_alu_with_traps_unit.sv */
// Top level of the stack VM 32-bit integer ALU with trap reporting.
// Depends on s32a_pkg, s32a_front, s32a_div_step and s32a_back.
//
//   channel   dir  tdata                     tuser
//   s_axis    in   lhs[31:0], rhs[63:32]     op[4:0]
//   m_axis    out  value[31:0]               trap_code[1:0]
//
// Every operation takes the same path: input register, decode stage, 32
// divider steps (one quotient bit each) and the output register. One item is
// taken per cycle while the pipeline advances. The whole pipeline advances
// together; it holds only while the output register is full and not taken.
// Reset clears all valid bits at once.
`default_nettype none
module stack_vm_int32_alu_with_traps_unit
  import s32a_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // lhs[31:0], rhs[63:32]
  input  wire logic [4:0]  s_axis_tuser,   // op[4:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // value[31:0]
  output logic [1:0]       m_axis_tuser    // trap_code[1:0]
);

  logic   en;
  logic   vld [0:XLEN];
  stage_t pl  [0:XLEN];

  // Advance whenever the output register can take a result
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  s32a_front u_front (
    .clk, .rst, .en,
    .in_vld (s_axis_tvalid),
    .in_op  (s_axis_tuser),
    .in_lhs (s_axis_tdata[31:0]),
    .in_rhs (s_axis_tdata[63:32]),
    .out_vld(vld[0]),
    .out_pl (pl[0])
  );

  for (genvar i = 0; i < XLEN; i++) begin : g_div
    s32a_div_step u_step (
      .clk, .rst, .en,
      .in_vld (vld[i]),
      .in_pl  (pl[i]),
      .out_vld(vld[i+1]),
      .out_pl (pl[i+1])
    );
  end

  s32a_back u_back (
    .clk, .rst, .en,
    .in_vld   (vld[XLEN]),
    .in_pl    (pl[XLEN]),
    .out_vld  (m_axis_tvalid),
    .out_value(m_axis_tdata),
    .out_trap (m_axis_tuser)
  );

  a_trap_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != TRAP_NONE) |-> (m_axis_tdata == '0))
    else $error("trapping result carries a nonzero value");

  a_trap_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined trap code");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

/* test/stack_vm_int32_alu_with_traps_unit_tb.sv */
// Self-checking testbench for the stack VM 32-bit integer ALU with traps.
// Depends on s32a_pkg and stack_vm_int32_alu_with_traps_unit; drives a directed
// table and random operations, comparing every result with a table entry or a local predictor.
`default_nettype none
module stack_vm_int32_alu_with_traps_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s32a_pkg::*;

  localparam int unsigned N_RANDOM = 1200;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [31:0] value;
    trap_t       trap;
  } alu_result_t;

  typedef struct {
    logic [4:0]  op;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic        known;
    alu_result_t res;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  alu_result_t pending_results[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_traps = 0;
  logic        stim_done = 1'b0;

  stack_vm_int32_alu_with_traps_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // lhs[31:0], rhs[63:32]
    .s_axis_tuser  (s_axis_tuser),   // op[4:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // value[31:0]
    .m_axis_tuser  (m_axis_tuser)    // trap_code[1:0]
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Compute the expected value and trap code of one operation
  function automatic alu_result_t alu_predict(logic [4:0] op, logic [31:0] a,
                                              logic [31:0] b);
    alu_result_t r;
    logic [31:0] q;
    r.value = '0;
    r.trap = TRAP_NONE;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_SDIV: begin
        if (b == 0) r.trap = TRAP_DIV0;
        else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r.trap = TRAP_OVF;
        else begin
          q = magnitude(a) / magnitude(b);
          r.value = (a[31] ^ b[31]) ? (32'd0 - q) : q;
        end
      end
      OP_UDIV: if (b == 0) r.trap = TRAP_DIV0; else r.value = a / b;
      OP_SREM: begin
        if (b == 0) r.trap = TRAP_DIV0;
        else begin
          q = magnitude(a) % magnitude(b);
          r.value = a[31] ? (32'd0 - q) : q;
        end
      end
      OP_UREM: if (b == 0) r.trap = TRAP_DIV0; else r.value = a % b;
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_SHL: r.value = (b >= 32) ? 32'd0 : (a << b[4:0]);
      OP_SHR: r.value = (b >= 32) ? 32'd0 : (a >> b[4:0]);
      OP_SAR: r.value = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      OP_EQ:  r.value = {31'd0, a == b};
      OP_SLT: r.value = {31'd0, $signed(a) < $signed(b)};
      OP_SLE: r.value = {31'd0, $signed(a) <= $signed(b)};
      OP_ULT: r.value = {31'd0, a < b};
      OP_ULE: r.value = {31'd0, a <= b};
      default: ;
    endcase
    return r;
  endfunction

  // Random operand biased toward edge values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      5: return 32'd0 - $urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  // Idle for a random gap, then hold the transfer until it is taken
  task automatic send_op(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, a};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_sent++;
  endtask

  // Stimulus: directed table then random operations
  initial begin
    vector_t dir_table[$];
    alu_result_t exp_r;
    logic [4:0] op;
    logic [31:0] a, b;
    dir_table = '{
      '{OP_ADD,  32'hFFFF_FFFF, 32'd1,         1'b1, '{32'd0, TRAP_NONE}},
      '{OP_SUB,  32'd0,         32'd1,         1'b1, '{32'hFFFF_FFFF, TRAP_NONE}},
      '{OP_MUL,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '{32'd0, TRAP_NONE}},
      '{OP_SDIV, 32'd5,         32'd0,         1'b1, '{32'd0, TRAP_DIV0}},
      '{OP_SDIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'd0, TRAP_OVF}},
      '{OP_SDIV, 32'hFFFF_FFF9, 32'd2,         1'b0, '{32'd0, TRAP_NONE}},
      '{OP_UDIV, 32'hFFFF_FFFF, 32'd0,         1'b1, '{32'd0, TRAP_DIV0}},
      '{OP_UDIV, 32'hFFFF_FFFF, 32'd1,         1'b1, '{32'hFFFF_FFFF, TRAP_NONE}},
      '{OP_SREM, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'd0, TRAP_NONE}},
      '{OP_SREM, 32'hFFFF_FFF9, 32'd2,         1'b0, '{32'd0, TRAP_NONE}},
      '{OP_SREM, 32'd7,         32'd0,         1'b1, '{32'd0, TRAP_DIV0}},
      '{OP_UREM, 32'd7,         32'd0,         1'b1, '{32'd0, TRAP_DIV0}},
      '{OP_UREM, 32'hFFFF_FFFF, 32'd10,        1'b0, '{32'd0, TRAP_NONE}},
      '{OP_AND,  32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b0, '{32'd0, TRAP_NONE}},
      '{OP_OR,   32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, '{32'd0, TRAP_NONE}},
      '{OP_XOR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, TRAP_NONE}},
      '{OP_SHL,  32'hFFFF_FFFF, 32'd32,        1'b1, '{32'd0, TRAP_NONE}},
      '{OP_SHL,  32'd1,         32'd31,        1'b1, '{32'h8000_0000, TRAP_NONE}},
      '{OP_SHR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, TRAP_NONE}},
      '{OP_SAR,  32'h8000_0000, 32'h8000_0000, 1'b1, '{32'hFFFF_FFFF, TRAP_NONE}},
      '{OP_SAR,  32'h8000_0000, 32'd31,        1'b1, '{32'hFFFF_FFFF, TRAP_NONE}},
      '{OP_EQ,   32'h8000_0000, 32'h8000_0000, 1'b1, '{32'd1, TRAP_NONE}},
      '{OP_SLT,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'd1, TRAP_NONE}},
      '{OP_SLE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'd0, TRAP_NONE}},
      '{OP_ULT,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'd1, TRAP_NONE}},
      '{OP_ULE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd1, TRAP_NONE}},
      '{5'd31,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, TRAP_NONE}}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_table[i]) begin
      exp_r = dir_table[i].known ? dir_table[i].res
            : alu_predict(dir_table[i].op, dir_table[i].lhs, dir_table[i].rhs);
      pending_results.push_back(exp_r);
      send_op(dir_table[i].op, dir_table[i].lhs, dir_table[i].rhs);
    end
    // Random phase: mostly defined ops, a few unknown codes
    for (int i = 0; i < N_RANDOM; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                        : 5'($urandom_range(0, 17));
      a = pick_operand();
      b = pick_operand();
      if (op inside {OP_SHL, OP_SHR, OP_SAR} && $urandom_range(0, 1))
        b = $urandom_range(0, 40);
      pending_results.push_back(alu_predict(op, a, b));
      send_op(op, a, b);
    end
    s_axis_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver: wait a random number of cycles per result, then take it
  initial begin
    int unsigned stall;
    forever begin
      stall = $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result value=%h trap=%0d", m_axis_tdata, m_axis_tuser);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (exp_r.trap != TRAP_NONE) n_traps++;
        if (m_axis_tdata !== exp_r.value) begin
          $error("value: expected %h actual %h", exp_r.value, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tuser !== exp_r.trap) begin
          $error("trap_code: expected %0d actual %0d", exp_r.trap, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done === 1'b1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d operations, %0d results checked, %0d traps.",
             n_sent, n_checked, n_traps);
    if (n_errors == 0) $display("stack_vm_int32_alu_with_traps_unit_tb OK");
    else $display("stack_vm_int32_alu_with_traps_unit_tb NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("stack_vm_int32_alu_with_traps_unit_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/s32a_pkg.sv
rtl/s32a_front.sv
rtl/s32a_div_step.sv
rtl/s32a_back.sv
rtl/stack_vm_int32_alu_with_traps_unit.sv
test/stack_vm_int32_alu_with_traps_unit_tb.sv
